// ===== design/rme_pkg.sv =====
// Package for the range median / moving-average filter.
// Holds field widths, reset values, parameter defaults and configuration register codes.
// No dependencies; every other design file refers to it by scoped names.
package rme_pkg;

  // Field widths fixed by the item format.
  localparam int MM_W      = 13;
  localparam int DIST_W    = 16;
  localparam int ALPHA_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  // Parameter defaults.
  localparam int WINDOW_DEF        = 5;
  localparam int FRACTION_BITS_DEF = 8;

  // Reset values of the registers and the filter state.
  localparam logic [MM_W-1:0]    RESET_MAX_RANGE    = 13'd8000;
  localparam logic [ALPHA_W-1:0] RESET_ALPHA_SHIFT  = 3'd2;
  localparam logic [MM_W-1:0]    RESET_DEFAULT_SEED = 13'd200;
  localparam logic [MM_W-1:0]    RESET_FILL         = 13'd200;

  // Input item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SEED   = 1'b1;

  typedef logic [MM_W-1:0] mm_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RANGE    = 2'd0,
    CFG_ALPHA_SHIFT  = 2'd1,
    CFG_DEFAULT_SEED = 2'd2
  } cfg_idx_t;

endpackage

// ===== design/rme_in_if.sv =====
// Input channel of the filter: valid/ready handshake with one sample or seed item.
// Depends on rme_pkg for the field widths.
interface rme_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rme_pkg::DIST_W-1:0]    distance_mm;

  modport source (output valid, output kind, output distance_mm, input ready);
  modport sink   (input valid, input kind, input distance_mm, output ready);
endinterface

// ===== design/rme_out_if.sv =====
// Result channel of the filter: valid/ready handshake with one result item.
// Depends on rme_pkg for the field widths.
interface rme_out_if;
  logic                       valid;
  logic                       ready;
  logic [rme_pkg::MM_W-1:0]   filtered_mm;
  logic [rme_pkg::MM_W-1:0]   median_mm;
  logic                       accepted;

  modport source (output valid, output filtered_mm, output median_mm, output accepted,
                  input ready);
  modport sink   (input valid, input filtered_mm, input median_mm, input accepted,
                  output ready);
endinterface

// ===== design/rme_median.sv =====
// Combinational median of a small window of samples, found by ranking every entry.
// Depends on rme_pkg for the sample width.
module rme_median #(
  parameter int WINDOW = rme_pkg::WINDOW_DEF
) (
  input  logic [WINDOW-1:0][rme_pkg::MM_W-1:0] samples,
  output rme_pkg::mm_t                         median
);

  localparam int CNT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] MID = CNT_W'(WINDOW / 2);

  logic [CNT_W-1:0] rank [WINDOW];

  // Rank of each entry in sorted order; equal values are ordered by position,
  // so exactly one entry holds the middle rank.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((samples[j] < samples[i]) || ((samples[j] == samples[i]) && (j < i))) begin
            rank[i] = rank[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  // Pick the entry whose rank is the middle one.
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == MID) begin
        median = samples[i];
      end
    end
  end

endmodule

// ===== design/range_median_ema_filter.sv =====
// Range filter: sample ring median followed by a shift-weighted moving average.
// An accepted item is held in the input register; its result is then registered in the result register.
// Throughput: one item per cycle while out_chan.ready holds; the input register drains when the result slot frees up.
// Timing is set by the ranking median network feeding the average update combinationally.
// Reset (synchronous, rst_n low): ring entries 200, write slot 0, average 200.0,
// max_range 8000, alpha_shift 2, default_seed 200, both pipeline stages empty.
module range_median_ema_filter #(
  parameter int WINDOW        = rme_pkg::WINDOW_DEF,
  parameter int FRACTION_BITS = rme_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rme_in_if.sink                            in_chan,
  rme_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [rme_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [rme_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int AVG_W  = rme_pkg::MM_W + FRACTION_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [AVG_W:0]    HALF      = (AVG_W + 1)'(1) << (FRACTION_BITS - 1);

  // Configuration registers.
  rme_pkg::mm_t                  max_range_r;
  logic [rme_pkg::ALPHA_W-1:0]   alpha_r;
  rme_pkg::mm_t                  default_seed_r;

  // Input register.
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_kind_r;
  logic [rme_pkg::DIST_W-1:0]    s1_dist_r;

  // Filter state.
  logic [WINDOW-1:0][rme_pkg::MM_W-1:0] ring_r, ring_nxt, ring_upd, med_in;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [AVG_W-1:0]              avg_r, avg_nxt, avg_upd, avg_out;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  rme_pkg::mm_t                  out_filt_r, out_med_r;
  logic                          out_acc_r;

  logic                          in_fire, s1_fire, out_free;
  logic                          sample_ok, take_sample;
  rme_pkg::mm_t                  seed_val, ring_med, med_sel;
  logic signed [AVG_W:0]         diff, step;
  logic [AVG_W:0]                rnd_sum;

  // Handshake: the input register moves on whenever the result register can take an item.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r    <= rme_pkg::RESET_MAX_RANGE;
      alpha_r        <= rme_pkg::RESET_ALPHA_SHIFT;
      default_seed_r <= rme_pkg::RESET_DEFAULT_SEED;
    end else if (cfg_we) begin
      case (cfg_addr)
        rme_pkg::CFG_MAX_RANGE:    max_range_r    <= cfg_wdata[rme_pkg::MM_W-1:0];
        rme_pkg::CFG_ALPHA_SHIFT:  alpha_r        <= cfg_wdata[rme_pkg::ALPHA_W-1:0];
        rme_pkg::CFG_DEFAULT_SEED: default_seed_r <= cfg_wdata[rme_pkg::MM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample qualification and the ring with the new sample written in.
  always_comb begin
    sample_ok   = (s1_dist_r != '0) &&
                  (s1_dist_r < {{(rme_pkg::DIST_W - rme_pkg::MM_W){1'b0}}, max_range_r});
    take_sample = !s1_kind_r && sample_ok;
    seed_val    = sample_ok ? s1_dist_r[rme_pkg::MM_W-1:0] : default_seed_r;
    for (int k = 0; k < WINDOW; k++) begin
      ring_upd[k] = (slot_r == SLOT_W'(k)) ? s1_dist_r[rme_pkg::MM_W-1:0] : ring_r[k];
    end
    med_in = take_sample ? ring_upd : ring_r;
  end

  rme_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .samples (med_in),
    .median  (ring_med)
  );

  // Average step toward the median; the arithmetic shift rounds toward minus infinity.
  always_comb begin
    diff    = $signed({1'b0, ring_med, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, avg_r});
    step    = diff >>> alpha_r;
    avg_upd = avg_r + step[AVG_W-1:0];
  end

  // Next state and result selection for seed, accepted sample and rejected sample.
  always_comb begin
    ring_nxt = ring_r;
    slot_nxt = slot_r;
    avg_nxt  = avg_r;
    med_sel  = ring_med;
    avg_out  = avg_r;
    if (s1_kind_r) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_nxt[k] = seed_val;
      end
      slot_nxt = '0;
      avg_nxt  = {seed_val, {FRACTION_BITS{1'b0}}};
      med_sel  = seed_val;
      avg_out  = {seed_val, {FRACTION_BITS{1'b0}}};
    end else if (sample_ok) begin
      ring_nxt = ring_upd;
      slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
      avg_nxt  = avg_upd;
      avg_out  = avg_upd;
    end
    rnd_sum = {1'b0, avg_out} + HALF;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_chan.kind;
      s1_dist_r <= in_chan.distance_mm;
    end
  end

  // Filter state, updated once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_r[k] <= rme_pkg::RESET_FILL;
      end
      slot_r <= '0;
      avg_r  <= {rme_pkg::RESET_FILL, {FRACTION_BITS{1'b0}}};
    end else if (s1_fire) begin
      ring_r <= ring_nxt;
      slot_r <= slot_nxt;
      avg_r  <= avg_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_filt_r <= rnd_sum[FRACTION_BITS + rme_pkg::MM_W - 1:FRACTION_BITS];
      out_med_r  <= med_sel;
      out_acc_r  <= s1_kind_r || sample_ok;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.filtered_mm = out_filt_r;
  assign out_chan.median_mm   = out_med_r;
  assign out_chan.accepted    = out_acc_r;

`ifndef SYNTHESIS
  // The write slot always points at an existing ring entry.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("write slot out of range");

  // A seed item reports its own value as both average and median.
  a_seed_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_kind_r) |=>
      (out_filt_r == out_med_r) && out_acc_r)
    else $error("seed result mismatch");

  // A rejected sample leaves the average and the ring untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_kind_r && !sample_ok) |=> ($stable(avg_r) && $stable(ring_r)))
    else $error("rejected sample changed state");

  // With no averaging weight the average lands exactly on the median.
  a_zero_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && take_sample && (alpha_r == '0)) |=>
      (avg_r == {out_med_r, {FRACTION_BITS{1'b0}}}))
    else $error("zero shift average differs from median");
`endif

endmodule
